/* design/vdt_pkg.sv */
// ----------------------------------------------------------------------------
// vdt_pkg: shared types and helpers for the vertex dedup table
// Entry layout, operation codes, the word that walks the cell row, and the
// wildcard compare and fill functions used by every cell.
// ----------------------------------------------------------------------------
package vdt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int INDEX_WIDTH = 24;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // stream packing
    localparam int IN_RAW_W  = 4 * INDEX_WIDTH + SLOT_W;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = SLOT_W + 4 * INDEX_WIDTH + CNT_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int IN_USER_W  = 3;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef logic [INDEX_WIDTH-1:0] index_t;

    typedef struct packed {
        index_t texcoord;
        index_t color;
        index_t normal;
        index_t pos;
    } entry_t;

    // word handed from cell to cell
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic              share;
        entry_t            req;
        logic [SLOT_W-1:0] read_slot;
        logic [SLOT_W-1:0] idx;
        logic [CNT_W-1:0]  count;
        logic              found;
        logic              is_new;
        logic [SLOT_W-1:0] slot;
        entry_t            data;
    } token_t;

    function automatic logic is_set(input index_t v);
        return ~v[INDEX_WIDTH-1];
    endfunction

    function automatic logic field_ok(input index_t e, input index_t r);
        return (e == r) || !is_set(e) || !is_set(r);
    endfunction

    function automatic logic compatible(input entry_t e, input entry_t r);
        return field_ok(e.pos, r.pos) && field_ok(e.normal, r.normal) &&
               field_ok(e.color, r.color) && field_ok(e.texcoord, r.texcoord);
    endfunction

    function automatic entry_t fill_entry(input entry_t e, input entry_t r);
        entry_t f;
        f.pos      = is_set(r.pos)      ? r.pos      : e.pos;
        f.normal   = is_set(r.normal)   ? r.normal   : e.normal;
        f.color    = is_set(r.color)    ? r.color    : e.color;
        f.texcoord = is_set(r.texcoord) ? r.texcoord : e.texcoord;
        return f;
    endfunction

endpackage

/* design/vertex_dedup_wildcard_table_core.sv */
// ----------------------------------------------------------------------------
// vertex_dedup_wildcard_table_core: wildcard vertex dedup table
// Inserts, clears and reads a table of four-index vertex entries held in a
// row of cells that the request word walks through one slot per cycle.
// ----------------------------------------------------------------------------
// insert and read words walk the row of TABLE_DEPTH cells from the launch
// register to the finish register before the result word is built; clear
// and the unused op go straight from acceptance to the finish register
// one word at a time: a new word is taken only after the last result word
// is loaded into the output register, which waits while the result side stalls
// reset: clears the stored count and all valid flags; entries need no reset
module vertex_dedup_wildcard_table_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_index, normal_index, color_index, texcoord_index, read_slot
    input  logic [vdt_pkg::IN_W-1:0]         s_tdata,
    // op, share
    input  logic [vdt_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot, out_pos, out_normal, out_color, out_texcoord, entry_count, zero pad
    output logic [vdt_pkg::OUT_W-1:0]        m_tdata,
    // is_new, error_flag
    output logic [vdt_pkg::OUT_USER_W-1:0]   m_tuser
);

    localparam int IW = vdt_pkg::INDEX_WIDTH;
    localparam int SW = vdt_pkg::SLOT_W;
    localparam int DEPTH = vdt_pkg::TABLE_DEPTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t                        state_reg, state_next;
    vdt_pkg::token_t               launch_reg, launch_next;
    vdt_pkg::token_t               fin_reg, fin_next;
    logic [vdt_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [vdt_pkg::OUT_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [vdt_pkg::OUT_USER_W-1:0] m_tuser_reg, m_tuser_next;

    vdt_pkg::token_t               chain [0:DEPTH];
    vdt_pkg::token_t               in_tok;

    logic                          res_ok;
    logic                          res_is_new;
    logic [SW-1:0]                 res_slot;
    vdt_pkg::entry_t               res_data;
    logic [vdt_pkg::CNT_W-1:0]     res_count;

    assign chain[0] = launch_reg;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        vdt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    always_comb begin
        in_tok              = '0;
        in_tok.valid        = 1'b1;
        in_tok.op           = vdt_pkg::op_t'(s_tuser[1:0]);
        in_tok.share        = s_tuser[2];
        in_tok.req.pos      = s_tdata[IW-1:0];
        in_tok.req.normal   = s_tdata[2*IW-1:IW];
        in_tok.req.color    = s_tdata[3*IW-1:2*IW];
        in_tok.req.texcoord = s_tdata[4*IW-1:3*IW];
        in_tok.read_slot    = s_tdata[4*IW+SW-1:4*IW];
        in_tok.count        = count_reg;
    end

    // result of the finished word
    always_comb begin
        res_ok     = 1'b0;
        res_is_new = 1'b0;
        res_slot   = '0;
        res_data   = '0;
        res_count  = count_reg;
        case (fin_reg.op) inside
            vdt_pkg::OP_INSERT, vdt_pkg::OP_READ: begin
                res_ok = fin_reg.found;
                if (fin_reg.found) begin
                    res_is_new = fin_reg.is_new;
                    res_slot   = fin_reg.slot;
                    res_data   = fin_reg.data;
                    if (fin_reg.is_new) begin
                        res_count = count_reg + 1'b1;
                    end
                end
            end
            vdt_pkg::OP_CLEAR: begin
                res_ok    = 1'b1;
                res_count = '0;
            end
            default: begin
                res_ok = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        launch_next   = launch_reg;
        launch_next.valid = 1'b0;
        fin_next      = fin_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_tok.op == vdt_pkg::OP_INSERT || in_tok.op == vdt_pkg::OP_READ) begin
                        launch_next = in_tok;
                        state_next  = ST_SCAN;
                    end else begin
                        fin_next   = in_tok;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                if (chain[DEPTH].valid) begin
                    fin_next   = chain[DEPTH];
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(vdt_pkg::OUT_W - vdt_pkg::OUT_RAW_W){1'b0}},
                                     res_count, res_data.texcoord, res_data.color,
                                     res_data.normal, res_data.pos, res_slot};
                    m_tuser_next  = {!res_ok, res_is_new};
                    count_next    = res_count;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        fin_reg     <= fin_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launch_reg   <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launch_reg   <= launch_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* design/vdt_cell.sv */
// ----------------------------------------------------------------------------
// vdt_cell: one slot of the vertex dedup table
// Holds one entry. The request word passes through once per cycle; the cell
// matches and fills, appends, or serves a read when the word reaches it.
// ----------------------------------------------------------------------------
module vdt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  vdt_pkg::token_t tok_in,
    output vdt_pkg::token_t tok_out
);

    vdt_pkg::entry_t entry_reg;
    vdt_pkg::entry_t entry_next;
    vdt_pkg::token_t tok_reg;
    vdt_pkg::token_t tok_next;

    logic below_count;
    logic hit_match;
    logic hit_append;
    logic hit_read;

    assign below_count = {1'b0, tok_in.idx} < tok_in.count;

    assign hit_match  = tok_in.valid && (tok_in.op == vdt_pkg::OP_INSERT) &&
                        tok_in.share && !tok_in.found && below_count &&
                        vdt_pkg::compatible(entry_reg, tok_in.req);
    // the first free slot is reached only after every stored one was scanned
    assign hit_append = tok_in.valid && (tok_in.op == vdt_pkg::OP_INSERT) &&
                        !tok_in.found && ({1'b0, tok_in.idx} == tok_in.count);
    assign hit_read   = tok_in.valid && (tok_in.op == vdt_pkg::OP_READ) &&
                        below_count && (tok_in.idx == tok_in.read_slot);

    always_comb begin
        entry_next = entry_reg;
        tok_next   = tok_in;
        tok_next.idx = tok_in.idx + 1'b1;
        if (hit_match) begin
            entry_next = vdt_pkg::fill_entry(entry_reg, tok_in.req);
        end else if (hit_append) begin
            entry_next = tok_in.req;
        end
        if (hit_match || hit_append || hit_read) begin
            tok_next.found  = 1'b1;
            tok_next.is_new = hit_append;
            tok_next.slot   = tok_in.idx;
            tok_next.data   = entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* design/vdt_checker.sv */
// ----------------------------------------------------------------------------
// vdt_checker: port-level checks for the vertex dedup table
// Watches the stream ports of the core over time; attached by bind.
// ----------------------------------------------------------------------------
module vdt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [vdt_pkg::OUT_W-1:0]        m_tdata,
    input logic [vdt_pkg::OUT_USER_W-1:0]   m_tuser
);

    localparam int SW = vdt_pkg::SLOT_W;
    localparam int CNT_LO = vdt_pkg::SLOT_W + 4 * vdt_pkg::INDEX_WIDTH;
    localparam int CNT_HI = CNT_LO + vdt_pkg::CNT_W - 1;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word in flight: no acceptance right after another
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    // a failed step reports no slot and no append
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[SW-1:0] == '0 && !m_tuser[0])
        else $error("error result carries a slot or append flag");

    // an append always leaves at least one entry stored
    a_new_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[CNT_HI:CNT_LO] != '0)
        else $error("append reported with empty table");

endmodule

bind vertex_dedup_wildcard_table_core vdt_checker u_vdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for vertex_dedup_wildcard_table_core
// A short table of hand-picked words runs first: reads before any insert,
// index extremes, wildcard matching and filling, clear and the unused op.
// Random traffic follows, including a phase that fills the table to its limit.
// The sender works in bursts and the receiver stalls on its own pattern.
// Each result word is checked field by field against its row or a table model.
// ----------------------------------------------------------------------------
module tb;

    localparam int IW    = vdt_pkg::INDEX_WIDTH;
    localparam int SW    = vdt_pkg::SLOT_W;
    localparam int CW    = vdt_pkg::CNT_W;
    localparam int DEPTH = vdt_pkg::TABLE_DEPTH;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDX_MAX      = 2 ** (IW - 1) - 1;
    localparam int IDX_MIN      = -(2 ** (IW - 1));
    localparam int RANDOM_WORDS = 850;
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic [SW-1:0]     slot;
        logic              is_new;
        logic              err;
        vdt_pkg::entry_t   ent;
        logic [CW-1:0]     count;
    } vtx_result_t;

    typedef struct packed {
        logic [1:0]        op;
        logic              share;
        vdt_pkg::entry_t   req;
        logic [SW-1:0]     rd_slot;
        logic              typed;     // expected result given in the row
        vtx_result_t       typed_res;
    } step_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [vdt_pkg::IN_W-1:0]       s_tdata = '0;
    logic [vdt_pkg::IN_USER_W-1:0]  s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [vdt_pkg::OUT_W-1:0]      m_tdata;
    logic [vdt_pkg::OUT_USER_W-1:0] m_tuser;

    // local copy of the table
    vdt_pkg::entry_t  vtx_store [DEPTH];
    int unsigned      stored_n = 0;
    vtx_result_t      pending_results [$];
    step_row_t        directed_rows [$];

    int unsigned cyc = 0;
    int unsigned errors = 0;
    int unsigned accepted_n = 0;
    int unsigned n_append = 0, n_match = 0, n_full = 0;
    int unsigned n_read = 0, n_read_err = 0, n_clear = 0, n_unused = 0;
    int unsigned burst_left = 1;

    vertex_dedup_wildcard_table_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc,
                     pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic vdt_pkg::entry_t mk_entry(input int p, input int n, input int c,
                                                 input int t);
        return {vdt_pkg::index_t'(t), vdt_pkg::index_t'(c), vdt_pkg::index_t'(n),
                vdt_pkg::index_t'(p)};
    endfunction

    function automatic vtx_result_t mk_res(input int slot, input bit is_new, input bit err,
                                           input vdt_pkg::entry_t ent, input int count);
        vtx_result_t r;
        r.slot   = slot[SW-1:0];
        r.is_new = is_new;
        r.err    = err;
        r.ent    = ent;
        r.count  = count[CW-1:0];
        return r;
    endfunction

    function automatic step_row_t mk_row(input logic [1:0] op, input bit share,
                                         input vdt_pkg::entry_t req, input int rd,
                                         input bit typed, input vtx_result_t res);
        step_row_t r;
        r.op        = op;
        r.share     = share;
        r.req       = req;
        r.rd_slot   = rd[SW-1:0];
        r.typed     = typed;
        r.typed_res = res;
        return r;
    endfunction

    task automatic add_row(input step_row_t r);
        directed_rows = {directed_rows, r};
    endtask

    // every specified field of one side equals the other, or is a wildcard there
    function automatic bit entry_agrees(input vdt_pkg::entry_t stored,
                                        input vdt_pkg::entry_t req);
        logic [4*IW-1:0] sv, rv;
        vdt_pkg::index_t a, b;
        sv = stored;
        rv = req;
        for (int k = 0; k < 4; k++) begin
            a = sv[k*IW +: IW];
            b = rv[k*IW +: IW];
            if (a != b && !a[IW-1] && !b[IW-1])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic vdt_pkg::entry_t merge_specified(input vdt_pkg::entry_t stored,
                                                        input vdt_pkg::entry_t req);
        logic [4*IW-1:0] sv, rv;
        sv = stored;
        rv = req;
        for (int k = 0; k < 4; k++)
            if (!rv[k*IW + IW - 1])
                sv[k*IW +: IW] = rv[k*IW +: IW];
        return sv;
    endfunction

    function automatic vtx_result_t table_step(input step_row_t w);
        vtx_result_t r;
        bit hit;
        r = '0;
        hit = 1'b0;
        case (w.op)
            vdt_pkg::OP_INSERT: begin
                if (w.share) begin
                    for (int i = 0; i < stored_n && !hit; i++) begin
                        if (entry_agrees(vtx_store[i], w.req)) begin
                            vtx_store[i] = merge_specified(vtx_store[i], w.req);
                            r.slot = i[SW-1:0];
                            r.ent  = vtx_store[i];
                            hit    = 1'b1;
                            n_match++;
                        end
                    end
                end
                if (!hit) begin
                    if (stored_n < DEPTH) begin
                        vtx_store[stored_n] = w.req;
                        r.slot   = stored_n[SW-1:0];
                        r.is_new = 1'b1;
                        r.ent    = w.req;
                        stored_n++;
                        n_append++;
                    end else begin
                        r.err = 1'b1;
                        n_full++;
                    end
                end
            end
            vdt_pkg::OP_CLEAR: begin
                stored_n = 0;
                n_clear++;
            end
            vdt_pkg::OP_READ: begin
                n_read++;
                if (w.rd_slot < stored_n) begin
                    r.slot = w.rd_slot;
                    r.ent  = vtx_store[w.rd_slot];
                end else begin
                    r.err = 1'b1;
                    n_read_err++;
                end
            end
            default: n_unused++;
        endcase
        r.count = stored_n[CW-1:0];
        return r;
    endfunction

    // small pool for frequent matches, wildcards, and the odd full-range value
    function automatic vdt_pkg::index_t rand_index();
        vdt_pkg::index_t v;
        int pick;
        v = vdt_pkg::index_t'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 5)
            v[IW-1] = 1'b1;
        else if (pick < 17)
            v = vdt_pkg::index_t'($urandom_range(0, 7));
        else
            v[IW-1] = 1'b0;
        return v;
    endfunction

    // fill phase: mostly plain appends so the table runs full
    function automatic step_row_t rand_row(input int n);
        step_row_t r;
        int pick;
        bit filling;
        r = '0;
        filling = (n >= 300 && n < 650);
        pick = $urandom_range(0, 99);
        r.req     = {rand_index(), rand_index(), rand_index(), rand_index()};
        r.rd_slot = SW'($urandom_range(0, DEPTH - 1));
        if (n == 300) begin
            r.op = vdt_pkg::OP_CLEAR;
        end else if (filling) begin
            r.op    = (pick < 95) ? vdt_pkg::OP_INSERT : vdt_pkg::OP_READ;
            r.share = ($urandom_range(0, 9) == 0);
        end else begin
            if (pick < 65)
                r.op = vdt_pkg::OP_INSERT;
            else if (pick < 95)
                r.op = vdt_pkg::OP_READ;
            else if (pick < 98)
                r.op = vdt_pkg::OP_CLEAR;
            else
                r.op = OP_UNUSED;
            r.share = ($urandom_range(0, 3) != 0);
        end
        if (r.op == vdt_pkg::OP_READ && stored_n > 0 && $urandom_range(0, 3) != 0)
            r.rd_slot = SW'($urandom_range(0, stored_n - 1));
        return r;
    endfunction

    task automatic send_word(input step_row_t w);
        vtx_result_t res;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= vdt_pkg::IN_W'({w.rd_slot, w.req});
        s_tuser  <= {w.share, w.op};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        res = table_step(w);
        if (w.typed)
            res = w.typed_res;
        pending_results = {pending_results, res};
        accepted_n++;
    endtask

    task automatic sender_pause();
        int gap;
        burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                              : $urandom_range(1, 15);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("cycle %0d: %s mismatch, got %0h want %0h", cyc, what, got, want);
        errors++;
    endtask

    vtx_result_t seen, want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.slot   = m_tdata[0 +: SW];
            seen.ent    = m_tdata[SW +: 4*IW];
            seen.count  = m_tdata[SW + 4*IW +: CW];
            seen.is_new = m_tuser[0];
            seen.err    = m_tuser[1];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", longint'(m_tdata[63:0]),
                                longint'(0));
            end else begin
                want = pending_results.pop_front();
                if (seen.slot != want.slot)
                    report_mismatch("slot", longint'(seen.slot), longint'(want.slot));
                if (seen.is_new != want.is_new)
                    report_mismatch("is_new", longint'(seen.is_new), longint'(want.is_new));
                if (seen.err != want.err)
                    report_mismatch("error_flag", longint'(seen.err), longint'(want.err));
                if (seen.ent.pos != want.ent.pos)
                    report_mismatch("out_pos", longint'(seen.ent.pos),
                                    longint'(want.ent.pos));
                if (seen.ent.normal != want.ent.normal)
                    report_mismatch("out_normal", longint'(seen.ent.normal),
                                    longint'(want.ent.normal));
                if (seen.ent.color != want.ent.color)
                    report_mismatch("out_color", longint'(seen.ent.color),
                                    longint'(want.ent.color));
                if (seen.ent.texcoord != want.ent.texcoord)
                    report_mismatch("out_texcoord", longint'(seen.ent.texcoord),
                                    longint'(want.ent.texcoord));
                if (seen.count != want.count)
                    report_mismatch("entry_count", longint'(seen.count),
                                    longint'(want.count));
            end
        end
    end

    // receiver: one long hold-off early on, then a mix of stall patterns
    initial begin
        int kind, len;
        bit held;
        held = 1'b0;
        wait (aresetn);
        forever begin
            if (!held && accepted_n >= 40) begin
                held = 1'b1;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end
            kind = $urandom_range(0, 3);
            len  = (kind == 0) ? $urandom_range(1, 400) : $urandom_range(1, 60);
            for (int j = 0; j < len; j++) begin
                @(negedge aclk);
                case (kind)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= 1'b0;
                    default: m_tready <= (j % 4) != 3;
                endcase
            end
        end
    end

    initial begin
        vdt_pkg::entry_t z, e0, e2;
        z  = mk_entry(0, 0, 0, 0);
        e0 = mk_entry(IDX_MIN, IDX_MIN, IDX_MIN, IDX_MIN);
        e2 = mk_entry(5, -1, -1, -1);

        // reads, clear and the unused op on an empty table
        add_row(mk_row(vdt_pkg::OP_READ, 0, z, 0, 1, mk_res(0, 0, 1, z, 0)));
        add_row(mk_row(OP_UNUSED, 1, mk_entry(IDX_MAX, -1, 3, IDX_MIN), 255,
                       1, mk_res(0, 0, 0, z, 0)));
        add_row(mk_row(vdt_pkg::OP_CLEAR, 0, z, 0, 1, mk_res(0, 0, 0, z, 0)));
        // extremes of the index range
        add_row(mk_row(vdt_pkg::OP_INSERT, 0, z, 0, 1, mk_res(0, 1, 0, z, 1)));
        add_row(mk_row(vdt_pkg::OP_INSERT, 1,
                       mk_entry(IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX), 255, 1,
                       mk_res(1, 1, 0, mk_entry(IDX_MAX, IDX_MAX, IDX_MAX, IDX_MAX), 2)));
        // all wildcards match the first entry and change nothing
        add_row(mk_row(vdt_pkg::OP_INSERT, 1, e0, 0, 1, mk_res(0, 0, 0, z, 2)));
        // wildcard entry, then fills from later requests
        add_row(mk_row(vdt_pkg::OP_INSERT, 1, e2, 0, 0, '0));
        add_row(mk_row(vdt_pkg::OP_INSERT, 1, mk_entry(5, 3, -1, 7), 0, 0, '0));
        add_row(mk_row(vdt_pkg::OP_INSERT, 1, mk_entry(-1, 3, 9, IDX_MIN), 0, 0, '0));
        add_row(mk_row(vdt_pkg::OP_INSERT, 1, mk_entry(5, 4, 9, 7), 0, 0, '0));
        // no sharing: a duplicate is appended
        add_row(mk_row(vdt_pkg::OP_INSERT, 0, z, 0, 0, '0));
        add_row(mk_row(vdt_pkg::OP_READ, 1, z, 2, 0, '0));
        add_row(mk_row(vdt_pkg::OP_READ, 0, z, 4, 0, '0));
        add_row(mk_row(vdt_pkg::OP_READ, 0, z, 1, 0, '0));
        // out-of-range reads
        add_row(mk_row(vdt_pkg::OP_READ, 0, z, 5, 1, mk_res(0, 0, 1, z, 5)));
        add_row(mk_row(vdt_pkg::OP_READ, 0, mk_entry(IDX_MAX, 1, 2, 3), 255, 1,
                       mk_res(0, 0, 1, z, 5)));
        add_row(mk_row(OP_UNUSED, 0, e0, 0, 1, mk_res(0, 0, 0, z, 5)));
        add_row(mk_row(vdt_pkg::OP_CLEAR, 1, e0, 3, 1, mk_res(0, 0, 0, z, 0)));
        add_row(mk_row(vdt_pkg::OP_READ, 0, z, 0, 1, mk_res(0, 0, 1, z, 0)));
        // after a clear old entries must not match
        add_row(mk_row(vdt_pkg::OP_INSERT, 1, mk_entry(5, 3, 9, 7), 0, 0, '0));
        add_row(mk_row(vdt_pkg::OP_INSERT, 1, mk_entry(-1, -1, 9, -1), 0, 0, '0));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i]);
            sender_pause();
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            send_word(rand_row(n));
            sender_pause();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DEPTH + 8) @(posedge aclk);

        $display("%0d words: %0d appends, %0d wildcard matches, %0d full-table rejects",
                 accepted_n, n_append, n_match, n_full);
        $display("%0d reads (%0d out of range), %0d clears, %0d unused-op words, %0d errors",
                 n_read, n_read_err, n_clear, n_unused, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
